@@ rtl/core/ps2h_pkg.sv @@
// Package for the PS/2 host frame engine: event codes, frame positions,
// error codes, item structs and the parity helper.
// No dependencies; every rtl/core module uses it by scoped names.
package ps2h_pkg;

   // Event codes carried by an input item.
   localparam logic [1:0] OP_FALL  = 2'd0;
   localparam logic [1:0] OP_RISE  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Receive error codes.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_START  = 2'd1;
   localparam logic [1:0] ERR_PARITY = 2'd2;
   localparam logic [1:0] ERR_STOP   = 2'd3;

   // Positions within an 11-bit frame.
   localparam logic [3:0] POS_START  = 4'd0;
   localparam logic [3:0] POS_LAST_DATA = 4'd8;
   localparam logic [3:0] POS_PARITY = 4'd9;
   localparam logic [3:0] POS_STOP   = 4'd10;
   localparam logic [3:0] POS_ACK    = 4'd11;

   localparam int FrameBits = 11;

   // One input item.
   typedef struct packed {
      logic [1:0] op;
      logic       data_line;
      logic [7:0] tx_byte;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [1:0] rx_error;
      logic       resend_request;
      logic       drive_valid;
      logic       drive_bit;
      logic       ack_valid;
      logic       ack_ok;
   } rsp_item_type;

   // 1 when the byte holds an odd number of ones.
   function automatic logic odd_ones(input logic [7:0] value);
      odd_ones = ^value;
   endfunction

endpackage

@@ rtl/core/ps2h_host_frame_engine_unit.sv @@
// Top level of the PS/2 host frame engine.
// Depends on ps2h_pkg, ps2h_req_reg, ps2h_frame_core and ps2h_rsp_reg.
//
// Usage:
//   The req_ channel carries one event per item: a falling clock edge
//   (with the sampled data line), a rising clock edge, or the start of a
//   host write (with tx_byte). Every item produces exactly one result item
//   on the rsp_ channel: a received byte, a receive error with a resend
//   request, a data line level to drive, or the sampled acknowledge; an
//   event that does nothing gives a result with all fields zero.
//   After acceptance the item is held in the input register, the frame
//   logic works on it in one pass and the result is captured in the output
//   register together with the state update. Throughput is one item per
//   cycle while the output register is free or rsp_ready is high.
//   When the receiver holds rsp_ready low the finished result waits in the
//   output register while the next item still enters the input register;
//   req_ready falls only when both registers are full.
//   Synchronous reset empties both registers and returns the engine to
//   read mode with cleared positions, shift register and transmit frame.
module ps2_host_frame_engine_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic       req_data_line,
   input  logic [7:0] req_tx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic [1:0] rsp_rx_error,
   output logic       rsp_resend_request,
   output logic       rsp_drive_valid,
   output logic       rsp_drive_bit,
   output logic       rsp_ack_valid,
   output logic       rsp_ack_ok
);

   ps2h_pkg::req_item_type req_item;
   ps2h_pkg::req_item_type item;
   ps2h_pkg::rsp_item_type result;
   ps2h_pkg::rsp_item_type rsp_item;
   logic                   item_valid;
   logic                   result_ready;
   logic                   step;

   assign req_item.op        = req_op;
   assign req_item.data_line = req_data_line;
   assign req_item.tx_byte   = req_tx_byte;

   // The held item is processed when the result register can take it.
   assign step = item_valid && result_ready;

   ps2h_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (step)
   );

   ps2h_frame_core u_frame_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   ps2h_rsp_reg u_rsp_reg (
      .clock        (clock),
      .reset        (reset),
      .result_valid (item_valid),
      .result_ready (result_ready),
      .result       (result),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item)
   );

   assign rsp_rx_valid       = rsp_item.rx_valid;
   assign rsp_rx_byte        = rsp_item.rx_byte;
   assign rsp_rx_error       = rsp_item.rx_error;
   assign rsp_resend_request = rsp_item.resend_request;
   assign rsp_drive_valid    = rsp_item.drive_valid;
   assign rsp_drive_bit      = rsp_item.drive_bit;
   assign rsp_ack_valid      = rsp_item.ack_valid;
   assign rsp_ack_ok         = rsp_item.ack_ok;

endmodule

@@ rtl/core/ps2h_req_reg.sv @@
// Input register stage for the PS/2 host frame engine.
// Depends on ps2h_pkg for the item struct.
module ps2h_req_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ps2h_pkg::req_item_type req_item,
   output logic                  item_valid,
   output ps2h_pkg::req_item_type item,
   input  logic                  item_take
);

   logic                   valid_ff;
   logic                   valid_in;
   ps2h_pkg::req_item_type item_ff;
   logic                   load;

   // The stage refills whenever it is empty or its item moves on this cycle.
   assign req_ready = !valid_ff || item_take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload carries no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/core/ps2h_frame_core.sv @@
// Frame state and single-pass event logic of the PS/2 host frame engine.
// Depends on ps2h_pkg for codes, positions, structs and odd_ones.
module ps2h_frame_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ps2h_pkg::req_item_type item,
   output ps2h_pkg::rsp_item_type result
);

   logic        write_mode_ff, write_mode_in;
   logic [3:0]  rx_position_ff, rx_position_in;
   logic [7:0]  rx_shift_ff, rx_shift_in;
   logic [ps2h_pkg::FrameBits-1:0] tx_frame_ff, tx_frame_in;
   logic [3:0]  tx_position_ff, tx_position_in;
   logic [2:0]  bit_index;
   logic [7:0]  bit_mask;
   logic        tx_parity;

   // Data positions one to eight map onto bits zero to seven.
   assign bit_index = rx_position_ff[2:0] - 3'd1;
   assign bit_mask  = 8'd1 << bit_index;
   assign tx_parity = ~ps2h_pkg::odd_ones(item.tx_byte);

   // Next state and result for the item at the head of the input stage.
   always_comb begin
      write_mode_in  = write_mode_ff;
      rx_position_in = rx_position_ff;
      rx_shift_in    = rx_shift_ff;
      tx_frame_in    = tx_frame_ff;
      tx_position_in = tx_position_ff;
      result         = '0;

      case (item.op)
         ps2h_pkg::OP_FALL: begin
            if (!write_mode_ff) begin
               if (rx_position_ff == ps2h_pkg::POS_START) begin
                  if (item.data_line) begin
                     result.rx_error       = ps2h_pkg::ERR_START;
                     result.resend_request = 1'b1;
                     rx_position_in        = '0;
                     rx_shift_in           = '0;
                  end else begin
                     rx_position_in = 4'd1;
                  end
               end else if (rx_position_ff <= ps2h_pkg::POS_LAST_DATA) begin
                  if (item.data_line) begin
                     rx_shift_in = rx_shift_ff | bit_mask;
                  end
                  rx_position_in = rx_position_ff + 4'd1;
               end else if (rx_position_ff == ps2h_pkg::POS_PARITY) begin
                  if (ps2h_pkg::odd_ones(rx_shift_ff) == item.data_line) begin
                     result.rx_error       = ps2h_pkg::ERR_PARITY;
                     result.resend_request = 1'b1;
                     rx_position_in        = '0;
                     rx_shift_in           = '0;
                  end else begin
                     rx_position_in = rx_position_ff + 4'd1;
                  end
               end else if (rx_position_ff == ps2h_pkg::POS_STOP) begin
                  if (!item.data_line) begin
                     result.rx_error       = ps2h_pkg::ERR_STOP;
                     result.resend_request = 1'b1;
                  end else begin
                     result.rx_valid = 1'b1;
                     result.rx_byte  = rx_shift_ff;
                  end
                  rx_position_in = '0;
                  rx_shift_in    = '0;
               end else begin
                  // Position beyond the stop bit: start over quietly.
                  rx_position_in = '0;
                  rx_shift_in    = '0;
               end
            end else if (tx_position_ff < ps2h_pkg::POS_ACK) begin
               result.drive_valid = 1'b1;
               result.drive_bit   = tx_frame_ff[tx_position_ff];
               tx_position_in     = tx_position_ff + 4'd1;
            end
         end
         ps2h_pkg::OP_RISE: begin
            // Acknowledge is sampled on the rising edge after the stop bit.
            if (tx_position_ff == ps2h_pkg::POS_ACK) begin
               result.ack_valid = 1'b1;
               result.ack_ok    = !item.data_line;
               write_mode_in    = 1'b0;
               tx_frame_in      = '0;
               tx_position_in   = '0;
            end
         end
         ps2h_pkg::OP_WRITE: begin
            // Load the frame, drop any partial read and drive the start bit.
            tx_frame_in        = {1'b1, tx_parity, item.tx_byte, 1'b0};
            write_mode_in      = 1'b1;
            rx_position_in     = '0;
            rx_shift_in        = '0;
            result.drive_valid = 1'b1;
            result.drive_bit   = 1'b0;
            tx_position_in     = 4'd1;
         end
         default: begin
            // Unused event code: no change, empty result.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_mode_ff  <= 1'b0;
         rx_position_ff <= '0;
         rx_shift_ff    <= '0;
         tx_frame_ff    <= '0;
         tx_position_ff <= '0;
      end else if (step) begin
         write_mode_ff  <= write_mode_in;
         rx_position_ff <= rx_position_in;
         rx_shift_ff    <= rx_shift_in;
         tx_frame_ff    <= tx_frame_in;
         tx_position_ff <= tx_position_in;
      end
   end

endmodule

@@ rtl/core/ps2h_rsp_reg.sv @@
// Result register stage of the PS/2 host frame engine.
// Depends on ps2h_pkg for the result struct.
module ps2h_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   result_valid,
   output logic                   result_ready,
   input  ps2h_pkg::rsp_item_type result,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ps2h_pkg::rsp_item_type rsp_item
);

   logic                   valid_ff;
   logic                   valid_in;
   ps2h_pkg::rsp_item_type item_ff;
   logic                   load;

   // A new result enters when the register is empty or is being emptied.
   assign result_ready = !valid_ff || rsp_ready;
   assign load         = result_valid && result_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ rtl/core/ps2h_port_checker.sv @@
// Port-level checks for the PS/2 host frame engine, bound to the top level.
// Depends on the top level's ports and on ps2h_pkg for the error codes.
module ps2h_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_rx_valid,
   input logic [7:0] rsp_rx_byte,
   input logic [1:0] rsp_rx_error,
   input logic       rsp_resend_request,
   input logic       rsp_drive_valid,
   input logic       rsp_ack_valid
);

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A stalled result holds its byte and error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte) &&
         $stable(rsp_rx_error))
      else $error("stalled result changed");

   // A resend request goes with an error and only with one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rx_error != ps2h_pkg::ERR_NONE) == rsp_resend_request)
      else $error("resend request does not match error");

   // One event yields at most one kind of outcome.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_rx_valid, rsp_resend_request,
         rsp_drive_valid, rsp_ack_valid}))
      else $error("result mixes outcomes");

   // A byte is reported only with a good frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rx_valid |-> rsp_rx_byte == 8'd0)
      else $error("byte reported without a good frame");

endmodule

bind ps2_host_frame_engine_unit ps2h_port_checker u_ps2h_port_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_rx_valid       (rsp_rx_valid),
   .rsp_rx_byte        (rsp_rx_byte),
   .rsp_rx_error       (rsp_rx_error),
   .rsp_resend_request (rsp_resend_request),
   .rsp_drive_valid    (rsp_drive_valid),
   .rsp_ack_valid      (rsp_ack_valid)
);
